### rtl/debounced_input_hold_events_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for debounced input hold events
// Shared concurrent property forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_INPUT_HOLD_EVENTS_MACROS_SVH
`define DEBOUNCED_INPUT_HOLD_EVENTS_MACROS_SVH

// same-cycle implication
`define DIH_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DIH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dih_pkg.sv
// ----------------------------------------------------------------------------
// dih_pkg
// Constants and register codes for the debounced input hold event block.
// ----------------------------------------------------------------------------
package dih_pkg;

	localparam int unsigned MAX_EVENTS         = 4;
	localparam int unsigned DEFAULT_NUM_EVENTS = 4;
	localparam int unsigned ADDR_W             = 5;
	localparam int unsigned DATA_W             = 32;
	localparam int unsigned TIME_W             = 64;
	localparam int unsigned DELAY_MS_W         = 16;
	localparam int unsigned DLY_US_W           = 26;

	localparam logic [DLY_US_W-1:0] US_PER_MS     = DLY_US_W'(1000);
	localparam logic [31:0]         DEBOUNCE_RST  = 32'd50000;
	localparam logic                FLAG_MODE_RST = 1'b1;

	typedef enum logic [2:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_FLAG_MODE    = 3'd1,
		REG_EVENT_COUNT  = 3'd2,
		REG_EVENT_LEVELS = 3'd3,
		REG_DELAY0       = 3'd4,
		REG_DELAY1       = 3'd5,
		REG_DELAY2       = 3'd6,
		REG_DELAY3       = 3'd7
	} reg_idx_t;

endpackage

### rtl/debounced_input_hold_events.sv
// ----------------------------------------------------------------------------
// debounced_input_hold_events
// Lockout debounce of a polled level with sticky flags and hold-time events.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall   raw_level, time_us, clear_high, clear_low
//   out      source     out_valid/out_stall fired_mask, stable_out, high_seen, low_seen
//   cfg      APB        psel/penable/pready paddr, pwdata, prdata
//
// One item per cycle while the output is not stalled; a taken item passes through the
// input register and then the result register, around one 64-bit subtract-and-compare
// pass over the active event entries, before it appears at the output.
// Reset clears the control and debounce state and loads the register defaults.
// An output stall holds the result register and then the input register.
// ----------------------------------------------------------------------------
`include "debounced_input_hold_events_macros.svh"

module debounced_input_hold_events #(
	parameter int unsigned NUM_EVENTS = dih_pkg::DEFAULT_NUM_EVENTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         raw_level,
	input  logic [dih_pkg::TIME_W-1:0]   time_us,
	input  logic                         clear_high,
	input  logic                         clear_low,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [dih_pkg::MAX_EVENTS-1:0] fired_mask,
	output logic                         stable_out,
	output logic                         high_seen,
	output logic                         low_seen,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dih_pkg::ADDR_W-1:0]   paddr,
	input  logic [dih_pkg::DATA_W-1:0]   pwdata,
	output logic [dih_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import dih_pkg::*;

	localparam int unsigned ActiveLimit = (NUM_EVENTS < MAX_EVENTS) ? NUM_EVENTS : MAX_EVENTS;

	logic [31:0]             debounce_q;
	logic                    flag_mode_q;
	logic [2:0]              event_count_q;
	logic [MAX_EVENTS-1:0]   event_levels_q;
	logic [DELAY_MS_W-1:0]   delay_ms_q [MAX_EVENTS];
	logic [DLY_US_W-1:0]     dly_us_q [ActiveLimit];

	logic                    s1_valid;
	logic                    raw_s1;
	logic [TIME_W-1:0]       time_s1;
	logic                    clr_hi_s1;
	logic                    clr_lo_s1;

	logic                    out_valid_q;
	logic [MAX_EVENTS-1:0]   fired_mask_q;
	logic                    stable_out_q;
	logic                    high_seen_q;
	logic                    low_seen_q;

	logic                    started_q;
	logic                    stable_q;
	logic [TIME_W-1:0]       change_q;
	logic [TIME_W-1:0]       accept_time_q;
	logic [MAX_EVENTS-1:0]   marks_q;
	logic                    hi_flag_q;
	logic                    lo_flag_q;

	logic                    cfg_wr;
	reg_idx_t                cfg_idx;
	logic                    advance;
	logic                    in_take;
	logic                    stable_eff;
	logic                    back;
	logic                    acc;
	logic                    rezero;
	logic [TIME_W-1:0]       since_accept;
	logic [TIME_W-1:0]       since_change;
	logic [TIME_W-1:0]       elapsed;
	logic [MAX_EVENTS-1:0]   marks_eff;
	logic [MAX_EVENTS-1:0]   fire;
	logic                    hi_set;
	logic                    lo_set;
	logic                    hi_now;
	logic                    lo_now;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= DEBOUNCE_RST;
			flag_mode_q    <= FLAG_MODE_RST;
			event_count_q  <= '0;
			event_levels_q <= '0;
			for (int k = 0; k < MAX_EVENTS; k++) begin
				delay_ms_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DEBOUNCE:     debounce_q     <= pwdata;
				REG_FLAG_MODE:    flag_mode_q    <= pwdata[0];
				REG_EVENT_COUNT:  event_count_q  <= pwdata[2:0];
				REG_EVENT_LEVELS: event_levels_q <= pwdata[MAX_EVENTS-1:0];
				REG_DELAY0:       delay_ms_q[0]  <= pwdata[DELAY_MS_W-1:0];
				REG_DELAY1:       delay_ms_q[1]  <= pwdata[DELAY_MS_W-1:0];
				REG_DELAY2:       delay_ms_q[2]  <= pwdata[DELAY_MS_W-1:0];
				REG_DELAY3:       delay_ms_q[3]  <= pwdata[DELAY_MS_W-1:0];
				default: ;
			endcase
		end
	end

	// hold each active delay in microseconds, scaled at write time
	for (genvar i = 0; i < ActiveLimit; i++) begin : g_dly
		localparam logic [2:0] Idx = 3'(REG_DELAY0 + i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dly_us_q[i] <= '0;
			end else if (cfg_wr && (paddr[ADDR_W-1:2] == Idx)) begin
				dly_us_q[i] <= DLY_US_W'(pwdata[DELAY_MS_W-1:0]) * US_PER_MS;
			end
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_DEBOUNCE:     prdata = debounce_q;
			REG_FLAG_MODE:    prdata = {31'b0, flag_mode_q};
			REG_EVENT_COUNT:  prdata = {29'b0, event_count_q};
			REG_EVENT_LEVELS: prdata = {{(DATA_W-MAX_EVENTS){1'b0}}, event_levels_q};
			REG_DELAY0:       prdata = {{(DATA_W-DELAY_MS_W){1'b0}}, delay_ms_q[0]};
			REG_DELAY1:       prdata = {{(DATA_W-DELAY_MS_W){1'b0}}, delay_ms_q[1]};
			REG_DELAY2:       prdata = {{(DATA_W-DELAY_MS_W){1'b0}}, delay_ms_q[2]};
			REG_DELAY3:       prdata = {{(DATA_W-DELAY_MS_W){1'b0}}, delay_ms_q[3]};
			default:          prdata = '0;
		endcase
	end

	// handshake
	assign advance  = s1_valid && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_take) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			raw_s1    <= raw_level;
			time_s1   <= time_us;
			clr_hi_s1 <= clear_high;
			clr_lo_s1 <= clear_low;
		end
	end

	// debounce and event decision
	assign stable_eff   = started_q ? stable_q : raw_s1;
	assign back         = started_q && (time_s1 < change_q);
	assign since_accept = time_s1 - accept_time_q;
	assign since_change = time_s1 - change_q;
	assign acc          = !back && (raw_s1 != stable_eff) &&
	                      (since_accept > {32'b0, debounce_q});
	assign rezero       = !started_q || back || acc;
	assign elapsed      = rezero ? '0 : since_change;
	assign marks_eff    = acc ? '0 : marks_q;

	for (genvar i = 0; i < MAX_EVENTS; i++) begin : g_evt
		if (i < ActiveLimit) begin : g_on
			localparam logic [2:0] Idx = 3'(i);
			assign fire[i] = (Idx < event_count_q) && (raw_s1 == event_levels_q[i]) &&
			                 (elapsed >= {{(TIME_W-DLY_US_W){1'b0}}, dly_us_q[i]}) &&
			                 !marks_eff[i];
		end else begin : g_off
			assign fire[i] = 1'b0;
		end
	end

	assign hi_set = raw_s1 && (!flag_mode_q || acc);
	assign lo_set = !raw_s1 && (!flag_mode_q || acc);
	assign hi_now = hi_flag_q || hi_set;
	assign lo_now = lo_flag_q || lo_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q     <= 1'b0;
			stable_q      <= 1'b0;
			change_q      <= '0;
			accept_time_q <= '0;
			marks_q       <= '0;
			hi_flag_q     <= 1'b0;
			lo_flag_q     <= 1'b0;
		end else if (advance) begin
			started_q     <= 1'b1;
			stable_q      <= acc ? raw_s1 : stable_eff;
			change_q      <= rezero ? time_s1 : change_q;
			accept_time_q <= (back || acc) ? time_s1 : accept_time_q;
			marks_q       <= marks_eff | fire;
			hi_flag_q     <= hi_now && !clr_hi_s1;
			lo_flag_q     <= lo_now && !clr_lo_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fired_mask_q <= fire;
			stable_out_q <= acc ? raw_s1 : stable_eff;
			high_seen_q  <= hi_now;
			low_seen_q   <= lo_now;
		end
	end

	assign out_valid  = out_valid_q;
	assign fired_mask = fired_mask_q;
	assign stable_out = stable_out_q;
	assign high_seen  = high_seen_q;
	assign low_seen   = low_seen_q;

	`DIH_ASSERT_NEXT(a_started_after_item, advance, started_q, "state not seeded after an item")
	`DIH_ASSERT_NEXT(a_change_toggles, advance && acc, stable_q != $past(stable_q), "accepted change kept the level")
	`DIH_ASSERT_NEXT(a_fired_marked, advance, (fired_mask_q & ~marks_q) == '0, "fired entry left unmarked")
	`DIH_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall, out_valid_q && $stable(fired_mask_q) && $stable(stable_out_q), "stalled result changed")
	`DIH_ASSERT_SAME(a_stall_cause, in_stall, s1_valid && out_valid_q && out_stall, "input stalled without a blocked result")

endmodule

### tb/debounced_input_hold_events_tb.sv
// ----------------------------------------------------------------------------
// debounced_input_hold_events_tb
// Self-checking bench for the lockout debounce block with hold-time events.
// Polls are sent over the valid/stall input channel and registers are set over
// the APB port while the block is idle. A local predictor tracks the debounced
// level, lockout times, sticky flags and event marks, and every result item is
// checked field by field in order. Directed polls cover seeding, the lockout
// boundary, backwards time, timestamp extremes and event entries; random
// phases follow with new register settings, idle gaps and output stalls.
// ----------------------------------------------------------------------------
module debounced_input_hold_events_tb;

	import dih_pkg::*;

	localparam int unsigned ENTRY_LIMIT =
		(DEFAULT_NUM_EVENTS < MAX_EVENTS) ? DEFAULT_NUM_EVENTS : MAX_EVENTS;
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASES       = 10;
	localparam int PHASE_POLLS  = 110;
	localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic        lvl;
		logic [63:0] stamp;
		logic        clr_high;
		logic        clr_low;
	} poll_t;

	typedef struct {
		logic [MAX_EVENTS-1:0] fired;
		logic                  stable;
		logic                  high;
		logic                  low;
	} poll_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  raw_level;
	logic [TIME_W-1:0]     time_us;
	logic                  clear_high;
	logic                  clear_low;
	logic                  out_valid;
	logic                  out_stall;
	logic [MAX_EVENTS-1:0] fired_mask;
	logic                  stable_out;
	logic                  high_seen;
	logic                  low_seen;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [DATA_W-1:0]     pwdata;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;

	debounced_input_hold_events dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_level(raw_level),
		.time_us(time_us),
		.clear_high(clear_high),
		.clear_low(clear_low),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fired_mask(fired_mask),
		.stable_out(stable_out),
		.high_seen(high_seen),
		.low_seen(low_seen),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [31:0] cfg_debounce_us  = DEBOUNCE_RST;
	logic        cfg_flag_mode    = FLAG_MODE_RST;
	logic [2:0]  cfg_event_count  = '0;
	logic [3:0]  cfg_event_levels = '0;
	logic [15:0] cfg_delay_ms [MAX_EVENTS] = '{default: '0};

	logic                  seeded      = 1'b0;
	logic                  level_q     = 1'b0;
	logic [63:0]           change_us   = '0;
	logic [63:0]           accept_us   = '0;
	logic [MAX_EVENTS-1:0] done_marks  = '0;
	logic                  sticky_high = 1'b0;
	logic                  sticky_low  = 1'b0;

	poll_result_t pending_results [$];
	poll_result_t want_r;
	int           mismatches      = 0;
	int           results_checked = 0;
	int           idle_cycles     = 0;

	bit gaps_on   = 1'b0;
	bit stalls_on = 1'b0;
	bit long_hold = 1'b0;
	int stall_left = 0;

	logic [63:0] track_us    = '0;
	logic        track_level = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic poll_result_t predict_poll(input poll_t p);
		poll_result_t r;
		int           active;
		r.fired = '0;
		if (!seeded) begin
			seeded    = 1'b1;
			level_q   = p.lvl;
			change_us = p.stamp;
		end
		if (p.stamp < change_us) begin
			change_us = p.stamp;
			accept_us = p.stamp;
		end
		if (!cfg_flag_mode) begin
			if (p.lvl) sticky_high = 1'b1;
			else sticky_low = 1'b1;
		end
		if (p.lvl != level_q && (p.stamp - accept_us) > {32'd0, cfg_debounce_us}) begin
			accept_us = p.stamp;
			change_us = p.stamp;
			level_q   = p.lvl;
			if (cfg_flag_mode) begin
				if (p.lvl) sticky_high = 1'b1;
				else sticky_low = 1'b1;
			end
			done_marks = '0;
		end
		active = (cfg_event_count < ENTRY_LIMIT) ? int'(cfg_event_count) : ENTRY_LIMIT;
		for (int i = 0; i < active; i++) begin
			if (p.lvl == cfg_event_levels[i] && !done_marks[i] &&
			    (p.stamp - change_us) >= 64'(cfg_delay_ms[i]) * 64'(US_PER_MS)) begin
				done_marks[i] = 1'b1;
				r.fired[i]    = 1'b1;
			end
		end
		r.stable = level_q;
		r.high   = sticky_high;
		r.low    = sticky_low;
		if (p.clr_high) sticky_high = 1'b0;
		if (p.clr_low) sticky_low = 1'b0;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic poll_t next_poll();
		poll_t p;
		int    r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			p.lvl      = $urandom_range(0, 1);
			p.stamp    = {$urandom, $urandom};
			p.clr_high = $urandom_range(0, 1);
			p.clr_low  = $urandom_range(0, 1);
			track_us   = p.stamp;
			return p;
		end
		if (r < 12) track_us = track_us - 64'($urandom_range(1, 5000));
		else if (r < 15) track_us = track_us + 64'd70_000_000;
		else if (r < 18) track_us = track_us + 64'h1_0000_0000;
		else track_us = track_us + 64'($urandom_range(0, 2500));
		if ($urandom_range(0, 99) < 30) track_level = ~track_level;
		p.lvl      = track_level;
		p.stamp    = track_us;
		p.clr_high = ($urandom_range(0, 9) == 0);
		p.clr_low  = ($urandom_range(0, 9) == 0);
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50) $display("ERROR: result %0d: %s", results_checked, msg);
	endtask

	task automatic send_poll(input poll_t p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		raw_level  <= p.lvl;
		time_us    <= p.stamp;
		clear_high <= p.clr_high;
		clear_low  <= p.clr_low;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_poll(p));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEBOUNCE:     cfg_debounce_us = value;
			REG_FLAG_MODE:    cfg_flag_mode = value[0];
			REG_EVENT_COUNT:  cfg_event_count = value[2:0];
			REG_EVENT_LEVELS: cfg_event_levels = value[3:0];
			REG_DELAY0:       cfg_delay_ms[0] = value[15:0];
			REG_DELAY1:       cfg_delay_ms[1] = value[15:0];
			REG_DELAY2:       cfg_delay_ms[2] = value[15:0];
			REG_DELAY3:       cfg_delay_ms[3] = value[15:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_seed_and_lockout();
		send_poll(poll_t'{1'b1, 64'd5000, 1'b0, 1'b0});
		send_poll(poll_t'{1'b0, 64'd20000, 1'b0, 1'b0});
		send_poll(poll_t'{1'b0, 64'd50001, 1'b0, 1'b0});
		send_poll(poll_t'{1'b1, 64'd100001, 1'b0, 1'b0});
		send_poll(poll_t'{1'b1, 64'd100002, 1'b0, 1'b0});
		send_poll(poll_t'{1'b1, 64'd30, 1'b1, 1'b1});
		send_poll(poll_t'{1'b0, 64'd31, 1'b0, 1'b0});
	endtask

	task automatic test_event_entries();
		write_reg(REG_DEBOUNCE, 32'd0);
		write_reg(REG_FLAG_MODE, 32'd0);
		write_reg(REG_EVENT_LEVELS, 32'b0101);
		write_reg(REG_DELAY0, 32'd0);
		write_reg(REG_DELAY1, 32'd1);
		write_reg(REG_DELAY2, 32'd2);
		write_reg(REG_DELAY3, 32'd65535);
		write_reg(REG_EVENT_COUNT, 32'd4);
		send_poll(poll_t'{1'b1, 64'd0, 1'b0, 1'b0});
		send_poll(poll_t'{1'b1, 64'd2000, 1'b0, 1'b0});
		send_poll(poll_t'{1'b0, 64'd2001, 1'b0, 1'b0});
		send_poll(poll_t'{1'b0, 64'd3001, 1'b0, 1'b0});
		send_poll(poll_t'{1'b0, TIME_MAX, 1'b1, 1'b1});
		send_poll(poll_t'{1'b1, TIME_MAX, 1'b0, 1'b0});
		write_reg(REG_EVENT_COUNT, 32'd7);
		send_poll(poll_t'{1'b0, TIME_MAX, 1'b0, 1'b1});
		write_reg(REG_EVENT_COUNT, 32'd1);
		send_poll(poll_t'{1'b1, 64'h1000, 1'b0, 1'b0});
		write_reg(REG_EVENT_COUNT, 32'd4);
		send_poll(poll_t'{1'b1, 64'd70_000_000, 1'b1, 1'b0});
	endtask

	task automatic test_debounce_max();
		write_reg(REG_DEBOUNCE, 32'hFFFF_FFFF);
		write_reg(REG_FLAG_MODE, 32'd1);
		send_poll(poll_t'{1'b0, 64'd0, 1'b0, 1'b0});
		send_poll(poll_t'{1'b1, 64'hFFFF_FFFF, 1'b0, 1'b0});
		send_poll(poll_t'{1'b1, 64'h1_0000_0000, 1'b0, 1'b0});
		send_poll(poll_t'{1'b0, 64'h1_0000_0001, 1'b1, 1'b1});
	endtask

	task automatic load_random_config();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) write_reg(REG_DEBOUNCE, 32'd0);
		else if (r < 30) write_reg(REG_DEBOUNCE, 32'hFFFF_FFFF);
		else write_reg(REG_DEBOUNCE, $urandom_range(0, 3000));
		write_reg(REG_FLAG_MODE, $urandom_range(0, 1));
		if ($urandom_range(0, 1)) write_reg(REG_EVENT_COUNT, 32'd4);
		else write_reg(REG_EVENT_COUNT, $urandom_range(0, 7));
		write_reg(REG_EVENT_LEVELS, $urandom_range(0, 15));
		for (int i = 0; i < MAX_EVENTS; i++) begin
			r = $urandom_range(0, 99);
			write_reg(reg_idx_t'(REG_DELAY0 + i),
				(r < 10) ? 32'd65535 : (r < 30) ? 32'd0 : $urandom_range(1, 6));
		end
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < PHASES; ph++) begin
			load_random_config();
			gaps_on   = (ph % 3 != 2);
			stalls_on = (ph % 4 != 3);
			if ($urandom_range(0, 1)) track_us = 64'($urandom_range(0, 1000));
			else track_us = {$urandom, $urandom};
			repeat (PHASE_POLLS) send_poll(next_poll());
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		long_hold = 1'b1;
		repeat (40) send_poll(next_poll());
		wait_idle();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		repeat (20) send_poll(next_poll());
	endtask

	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (long_hold) begin
				long_hold  = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 99) < 20) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
					: $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("item with no expectation waiting");
			end else begin
				want_r = pending_results.pop_front();
				if (fired_mask !== want_r.fired)
					report_mismatch($sformatf("fired_mask expected %h got %h",
						want_r.fired, fired_mask));
				if (stable_out !== want_r.stable)
					report_mismatch($sformatf("stable_out expected %b got %b",
						want_r.stable, stable_out));
				if (high_seen !== want_r.high)
					report_mismatch($sformatf("high_seen expected %b got %b",
						want_r.high, high_seen));
				if (low_seen !== want_r.low)
					report_mismatch($sformatf("low_seen expected %b got %b",
						want_r.low, low_seen));
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable) ||
			    !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		raw_level  <= 1'b0;
		time_us    <= '0;
		clear_high <= 1'b0;
		clear_low  <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_seed_and_lockout();
		test_event_entries();
		test_debounce_max();
		test_backpressure();
		test_random_phases();
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/dih_pkg.sv
rtl/debounced_input_hold_events.sv
tb/debounced_input_hold_events_tb.sv
